@@ sv/ltc_timecode_biphase_generator_core_assert.svh @@
// ----------------------------------------------------------------------------
// ltc generator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef LTC_TIMECODE_BIPHASE_GENERATOR_CORE_ASSERT_SVH
`define LTC_TIMECODE_BIPHASE_GENERATOR_CORE_ASSERT_SVH

// condition that must hold at every clock edge
`define LTCG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define LTCG_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ sv/ltcg_pkg.sv @@
// ----------------------------------------------------------------------------
// ltcg_pkg
// types, constants and digit helpers of the ltc timecode generator
// ----------------------------------------------------------------------------
`default_nettype none

package ltcg_pkg;

    // frame layout
    localparam int unsigned BITS_PER_FRAME = 80;
    localparam logic [6:0]  LAST_BIT       = 7'(BITS_PER_FRAME - 1);
    localparam logic [15:0] SYNC_WORD      = 16'h3FFD;  // msb sent first at bit 64

    // counter limits
    localparam logic [6:0] SECONDS_LIMIT = 7'd60;
    localparam logic [6:0] MINUTES_LIMIT = 7'd60;
    localparam logic [5:0] HOURS_LIMIT   = 6'd24;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROPPED     = 2'd2;
    localparam logic [5:0] FRAME_LIMIT_RST = 6'd25;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [5:0] frames;
    } t_timecode;

    typedef struct packed {
        logic [5:0] frame_limit;
        logic       drop_mode;
        logic [2:0] dropped;
    } t_cfg;

    // tens digit of a value below 128, by reciprocal multiply (205/2048)
    function automatic logic [3:0] f_tens(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    // units digit of a value below 128
    function automatic logic [3:0] f_units(input logic [6:0] v);
        logic [6:0] t10;
        logic [6:0] r;
        t10 = 7'(f_tens(v)) * 7'd10;
        r   = v - t10;
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/ltcg_if.sv @@
// ----------------------------------------------------------------------------
// ltcg channel interfaces
// valid/ready channels for tick/load items and for result items
// ----------------------------------------------------------------------------
`default_nettype none

interface ltcg_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
    logic [5:0] load_frames;

    modport source (
        output valid, mode, load_hours, load_minutes, load_seconds, load_frames,
        input  ready
    );
    modport sink (
        input  valid, mode, load_hours, load_minutes, load_seconds, load_frames,
        output ready
    );
endinterface

interface ltcg_result_if;
    logic       valid;
    logic       ready;
    logic       line_level;
    logic [6:0] bit_position;
    logic [4:0] cur_hours;
    logic [5:0] cur_minutes;
    logic [5:0] cur_seconds;
    logic [5:0] cur_frames;

    modport source (
        output valid, line_level, bit_position, cur_hours, cur_minutes, cur_seconds,
               cur_frames,
        input  ready
    );
    modport sink (
        input  valid, line_level, bit_position, cur_hours, cur_minutes, cur_seconds,
               cur_frames,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/ltc_timecode_biphase_generator_core.sv @@
// ----------------------------------------------------------------------------
// ltc_timecode_biphase_generator_core
// smpte linear timecode generator with biphase-mark line coding
// ----------------------------------------------------------------------------
// usage:
//   i_item carries one item per handshake: mode 0 is one half-bit tick, mode 1
//   presets hours, minutes, seconds and frames. o_result returns one item for
//   each input item: line level, bit position and current timecode after it.
//   configuration (frame limit, drop mode, dropped frames) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
// pipeline and throughput:
//   an item is registered at the input, then the state update and the result
//   register load happen together once the result register is free.
//   one item per cycle while o_result.ready is high, set by the state update loop.
// reset:
//   i_rst_n low clears the timecode, bit position, half and level to zero,
//   loads the register reset values and empties both stages.
// stall:
//   while the result is not taken the input stage still takes one more item;
//   after that i_item.ready drops until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ltc_timecode_biphase_generator_core_assert.svh"

module ltc_timecode_biphase_generator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ltcg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ltcg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ltcg_item_if.sink                               i_item,
    ltcg_result_if.source                           o_result
);

    // configuration registers
    ltcg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_limit <= ltcg_pkg::FRAME_LIMIT_RST;
            r_cfg.drop_mode   <= 1'b0;
            r_cfg.dropped     <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ltcg_pkg::CFG_FRAME_LIMIT: r_cfg.frame_limit <= i_cfg_data;
                ltcg_pkg::CFG_DROP_MODE:   r_cfg.drop_mode   <= i_cfg_data[0];
                ltcg_pkg::CFG_DROPPED:     r_cfg.dropped     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // handshake control
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic proc;
    logic in_take;

    assign out_free       = !r_out_valid || o_result.ready;
    assign proc           = r_in_valid && out_free;
    assign i_item.ready   = !r_in_valid || proc;
    assign in_take        = i_item.valid && i_item.ready;
    assign o_result.valid = r_out_valid;

    // input stage
    logic                r_in_mode;
    ltcg_pkg::t_timecode r_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode         <= i_item.mode;
            r_in_load.hours   <= i_item.load_hours;
            r_in_load.minutes <= i_item.load_minutes;
            r_in_load.seconds <= i_item.load_seconds;
            r_in_load.frames  <= i_item.load_frames;
        end
    end

    // coder state
    ltcg_pkg::t_timecode r_tc, n_tc;
    logic [6:0]          r_bit_cnt, n_bit_cnt;
    logic                r_half, n_half;
    logic                r_level, n_level;
    ltcg_pkg::t_timecode tc_adv;
    logic                cur_bit;

    ltcg_frame_bit u_frame_bit (
        .i_idx       (r_bit_cnt),
        .i_tc        (r_tc),
        .i_drop_mode (r_cfg.drop_mode),
        .o_bit       (cur_bit)
    );

    ltcg_tc_counter u_tc_counter (
        .i_tc  (r_tc),
        .i_cfg (r_cfg),
        .o_tc  (tc_adv)
    );

    // load, first half-bit or second half-bit
    always_comb begin
        n_tc      = r_tc;
        n_bit_cnt = r_bit_cnt;
        n_half    = r_half;
        n_level   = r_level;
        priority if (r_in_mode) begin
            n_tc = r_in_load;
        end else if (!r_half) begin
            n_level = r_level ^ cur_bit;
            n_half  = 1'b1;
        end else begin
            n_level = !r_level;
            n_half  = 1'b0;
            if (r_bit_cnt >= ltcg_pkg::LAST_BIT) begin
                n_bit_cnt = '0;
                n_tc      = tc_adv;
            end else begin
                n_bit_cnt = r_bit_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc      <= '0;
            r_bit_cnt <= '0;
            r_half    <= 1'b0;
            r_level   <= 1'b0;
        end else if (proc) begin
            r_tc      <= n_tc;
            r_bit_cnt <= n_bit_cnt;
            r_half    <= n_half;
            r_level   <= n_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            o_result.line_level   <= n_level;
            o_result.bit_position <= n_bit_cnt;
            o_result.cur_hours    <= n_tc.hours;
            o_result.cur_minutes  <= n_tc.minutes;
            o_result.cur_seconds  <= n_tc.seconds;
            o_result.cur_frames   <= n_tc.frames;
        end
    end

    // checks
    logic second_tick;
    logic hold_tick;

    assign second_tick = proc && !r_in_mode && r_half;
    assign hold_tick   = proc && (r_in_mode || !r_half);

    `LTCG_ASSERT_ALWAYS(a_bit_range, r_bit_cnt <= ltcg_pkg::LAST_BIT, "bit past frame end")
    `LTCG_ASSERT_NEXT(a_half2_toggle, second_tick, $changed(r_level), "second half kept level")
    `LTCG_ASSERT_NEXT(a_bit_holds, hold_tick, $stable(r_bit_cnt), "bit moved off second half")
    `LTCG_ASSERT_ALWAYS(a_empty_takes, !r_in_valid |-> i_item.ready, "empty stage refused item")

endmodule

`default_nettype wire

@@ sv/ltcg_frame_bit.sv @@
// ----------------------------------------------------------------------------
// ltcg_frame_bit
// value of one ltc frame bit from the live timecode and drop flag
// ----------------------------------------------------------------------------
`default_nettype none

module ltcg_frame_bit (
    input  wire logic [6:0]         i_idx,
    input  wire ltcg_pkg::t_timecode i_tc,
    input  wire logic               i_drop_mode,
    output logic                    o_bit
);

    logic [3:0] nib;

    // bcd nibble of the field that holds this bit
    always_comb begin
        unique case (i_idx[5:3])
            3'd0: nib = ltcg_pkg::f_units({1'b0, i_tc.frames});
            3'd1: nib = {1'b0, i_drop_mode, 2'(ltcg_pkg::f_tens({1'b0, i_tc.frames}))};
            3'd2: nib = ltcg_pkg::f_units({1'b0, i_tc.seconds});
            3'd3: nib = ltcg_pkg::f_tens({1'b0, i_tc.seconds}) & 4'h7;
            3'd4: nib = ltcg_pkg::f_units({1'b0, i_tc.minutes});
            3'd5: nib = ltcg_pkg::f_tens({1'b0, i_tc.minutes}) & 4'h7;
            3'd6: nib = ltcg_pkg::f_units({2'b00, i_tc.hours});
            default: nib = ltcg_pkg::f_tens({2'b00, i_tc.hours}) & 4'h3;
        endcase
    end

    // index past frame end, sync word region, data region, unused upper nibble of each byte
    always_comb begin
        priority if (i_idx > ltcg_pkg::LAST_BIT) begin
            o_bit = 1'b0;
        end else if (i_idx[6]) begin
            o_bit = ltcg_pkg::SYNC_WORD[~i_idx[3:0]];
        end else if (i_idx[2]) begin
            o_bit = 1'b0;
        end else begin
            o_bit = nib[i_idx[1:0]];
        end
    end

endmodule

`default_nettype wire

@@ sv/ltcg_tc_counter.sv @@
// ----------------------------------------------------------------------------
// ltcg_tc_counter
// one-frame advance of the timecode with drop-frame restart
// ----------------------------------------------------------------------------
`default_nettype none

module ltcg_tc_counter (
    input  wire ltcg_pkg::t_timecode i_tc,
    input  wire ltcg_pkg::t_cfg      i_cfg,
    output ltcg_pkg::t_timecode      o_tc
);

    logic [6:0] fr_inc;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hr_inc;

    assign fr_inc  = {1'b0, i_tc.frames} + 7'd1;
    assign sec_inc = {1'b0, i_tc.seconds} + 7'd1;
    assign min_inc = {1'b0, i_tc.minutes} + 7'd1;
    assign hr_inc  = {1'b0, i_tc.hours} + 6'd1;

    // frames, then seconds, minutes, hours ripple
    always_comb begin
        o_tc = i_tc;
        if (fr_inc < {1'b0, i_cfg.frame_limit}) begin
            o_tc.frames = fr_inc[5:0];
        end else begin
            o_tc.frames = '0;
            if (sec_inc < ltcg_pkg::SECONDS_LIMIT) begin
                o_tc.seconds = sec_inc[5:0];
            end else begin
                o_tc.seconds = '0;
                // non-tenth minute skips the first frame numbers
                if (i_cfg.drop_mode && (ltcg_pkg::f_units(min_inc) != 4'd0)) begin
                    o_tc.frames = {3'b000, i_cfg.dropped};
                end
                if (min_inc < ltcg_pkg::MINUTES_LIMIT) begin
                    o_tc.minutes = min_inc[5:0];
                end else begin
                    o_tc.minutes = '0;
                    o_tc.hours   = (hr_inc >= ltcg_pkg::HOURS_LIMIT) ? 5'd0 : hr_inc[4:0];
                end
            end
        end
    end

endmodule

`default_nettype wire
